@@ hdl/mtx_pkg.sv @@
// shared constants, types and tempering function for the mt19937 keystream xor block
`default_nettype none
package mtx_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned SHIFT_M     = 397;
  localparam int unsigned POS_W       = 10;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(STATE_WORDS - 1);
  localparam logic [POS_W-1:0] FAR_WRAP  = POS_W'(STATE_WORDS - SHIFT_M);
  localparam logic [POS_W-1:0] FAR_ADD   = POS_W'(SHIFT_M);
  localparam logic [POS_W-1:0] NXT2_WRAP = POS_W'(STATE_WORDS - 2);

  localparam logic [31:0] INIT_MULT = 32'h6c078965;
  localparam logic [31:0] TWIST_XOR = 32'h9908b0df;
  localparam logic [31:0] MID_BITS  = 32'h7ffffffe;
  localparam logic [31:0] TEMPER_B  = 32'hff3a58ad;
  localparam logic [31:0] TEMPER_C  = 32'hffffdf8c;

  // request from the stream side to the generator
  typedef struct packed {
    logic        go;
    logic        reseed;
    logic [31:0] seed;
  } gen_req_t;

  // generator status back to the stream side
  typedef struct packed {
    logic ready;
    logic key_valid;
  } gen_rsp_t;

  // generator sequencer states
  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SEED_MUL = 9'b000000010,
    ST_SEED_ADD = 9'b000000100,
    ST_TW_P0    = 9'b000001000,
    ST_TW_P1    = 9'b000010000,
    ST_TW_A     = 9'b000100000,
    ST_TW_B     = 9'b001000000,
    ST_OUT_RD   = 9'b010000000,
    ST_OUT_WR   = 9'b100000000
  } gen_state_t;

  // output tempering of one state word
  function automatic logic [31:0] temper(input logic [31:0] w);
    logic [31:0] r;
    r = w;
    r = r ^ (r >> 11);
    r = r ^ ((r & TEMPER_B) << 7);
    r = r ^ ((r & TEMPER_C) << 15);
    r = r ^ (r >> 18);
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hdl/mtx_gen.sv @@
// mt19937 generator: state memory, reseed sequencer, in-place twist and tempered read-out
`default_nettype none
module mtx_gen
  import mtx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire gen_req_t    req,
  input  wire logic        key_ready,
  output gen_rsp_t         rsp,
  output logic [31:0]      key
);

  gen_state_t state;
  gen_state_t state_next;

  logic [31:0]      mem [STATE_WORDS];
  logic [31:0]      rdata;
  logic [POS_W-1:0] raddr;
  logic [POS_W-1:0] waddr;
  logic [31:0]      wdata;
  logic             we;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] k;
  logic [31:0]      prev;
  logic [31:0]      prod;
  logic [31:0]      cur;
  logic [31:0]      nxt_w;

  logic [POS_W-1:0] far_addr;
  logic [POS_W-1:0] nxt2_addr;
  logic [31:0]      twisted;
  logic [31:0]      seed_word;

  // twist addressing and arithmetic
  assign far_addr  = (k < FAR_WRAP) ? (k + FAR_ADD) : (k - FAR_WRAP);
  assign nxt2_addr = (k >= NXT2_WRAP) ? (k - NXT2_WRAP) : (k + POS_W'(2));
  assign twisted   = ((((cur ^ nxt_w) & MID_BITS) ^ cur) >> 1)
                   ^ (nxt_w[0] ? TWIST_XOR : 32'd0) ^ rdata;
  assign seed_word = {{(32-POS_W){1'b0}}, k} + prod;

  // state memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  // memory port selection
  always_comb begin
    we    = 1'b0;
    waddr = k;
    wdata = twisted;
    raddr = pos;
    case (state)
      ST_IDLE: begin
        we    = req.go && req.reseed;
        waddr = '0;
        wdata = req.seed;
      end
      ST_SEED_ADD: begin
        we    = 1'b1;
        wdata = seed_word;
      end
      ST_TW_P0: raddr = '0;
      ST_TW_P1: raddr = POS_W'(1);
      ST_TW_A:  raddr = far_addr;
      ST_TW_B: begin
        we    = 1'b1;
        raddr = nxt2_addr;
      end
      default: raddr = pos;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.go) begin
          if (req.reseed) begin
            state_next = ST_SEED_MUL;
          end else if (pos == '0) begin
            state_next = ST_TW_P0;
          end else begin
            state_next = ST_OUT_RD;
          end
        end
      end
      ST_SEED_MUL: state_next = ST_SEED_ADD;
      ST_SEED_ADD: state_next = (k == LAST_POS) ? ST_TW_P0 : ST_SEED_MUL;
      ST_TW_P0:    state_next = ST_TW_P1;
      ST_TW_P1:    state_next = ST_TW_A;
      ST_TW_A:     state_next = ST_TW_B;
      ST_TW_B:     state_next = (k == LAST_POS) ? ST_OUT_RD : ST_TW_A;
      ST_OUT_RD:   state_next = ST_OUT_WR;
      ST_OUT_WR:   state_next = key_ready ? ST_IDLE : ST_OUT_WR;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && req.go && req.reseed) begin
        pos <= '0;
      end else if (state == ST_OUT_WR && key_ready) begin
        pos <= (pos == LAST_POS) ? '0 : pos + POS_W'(1);
      end
    end
  end

  // datapath registers for reseed and twist
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        prev <= req.seed;
        k    <= POS_W'(1);
      end
      ST_SEED_MUL: prod <= INIT_MULT * (prev ^ (prev >> 30));
      ST_SEED_ADD: begin
        prev <= seed_word;
        k    <= k + POS_W'(1);
      end
      ST_TW_P1: begin
        cur <= rdata;
        k   <= '0;
      end
      ST_TW_A: nxt_w <= rdata;
      ST_TW_B: begin
        cur <= nxt_w;
        k   <= k + POS_W'(1);
      end
      default: ;
    endcase
  end

  assign rsp.ready     = (state == ST_IDLE);
  assign rsp.key_valid = (state == ST_OUT_WR);
  assign key           = temper(rdata);

endmodule
`default_nettype wire

@@ hdl/mt19937_keystream_xor.sv @@
// Keystream xor: each request runs the sequencer steps (idle, read, deliver); a new request
// is taken only back in idle, and deliver waits while the receiver holds the output register.
// A request with first set adds a reseed walk (a multiply and an add step per word) plus a
// twist; a twist (two memory reads per word) also runs before every 624th result.
// Reset clears the sequencer, word position, byte_mode and the output valid flag; the state
// memory is not cleared and is defined only after the first reseed.
`default_nettype none
module mt19937_keystream_xor
  import mtx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_mode_we,
  input  wire logic        byte_mode_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // data_in [31:0], seed_in [63:32]
  input  wire logic        s_tuser,   // first
  input  wire logic        s_tlast,   // last_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // data_out [31:0]
  output logic             m_tlast    // last_out
);

  gen_req_t    req;
  gen_rsp_t    rsp;
  logic [31:0] key;
  logic        key_ready;
  logic        accept;
  logic        byte_mode;
  logic [31:0] data_q;
  logic        last_q;

  assign s_tready  = rsp.ready;
  assign accept    = s_tvalid && s_tready;
  assign key_ready = !m_tvalid || m_tready;

  assign req.go     = accept;
  assign req.reseed = s_tuser;
  assign req.seed   = s_tdata[63:32];

  mtx_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .key_ready (key_ready),
    .rsp       (rsp),
    .key       (key)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_mode <= 1'b0;
    end else if (byte_mode_we) begin
      byte_mode <= byte_mode_wdata;
    end
  end

  // request payload held while the generator runs
  always_ff @(posedge clk) begin
    if (accept) begin
      data_q <= s_tdata[31:0];
      last_q <= s_tlast;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rsp.key_valid && key_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.key_valid && key_ready) begin
      m_tdata <= byte_mode ? {24'd0, data_q[7:0] ^ key[7:0]} : (data_q ^ key);
      m_tlast <= last_q;
    end
  end

endmodule
`default_nettype wire

@@ dv/tb_mt19937_keystream_xor.sv @@
// self-checking testbench for the mt19937 keystream xor block, directed table then random buffers
`timescale 1ns / 1ps
module tb_mt19937_keystream_xor;
  import mtx_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 4_000_000;
  localparam int unsigned DRAIN_CYCLES = 50;
  localparam int unsigned SHOW_FAILS   = 10;
  localparam int unsigned DIR_ROWS     = 17;

  // one expected ciphertext result
  typedef struct packed {
    logic [31:0] data;
    logic        last;
  } cipher_result_t;

  // one directed request, with an optional hand-computed result
  typedef struct packed {
    logic        mode;
    logic [31:0] data;
    logic        first;
    logic [31:0] seed;
    logic        last;
    logic        fixed;
    logic [31:0] want;
  } directed_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        byte_mode_we = 1'b0;
  logic        byte_mode_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;       // data_in [31:0], seed_in [63:32]
  logic        s_tuser = 1'b0;     // first
  logic        s_tlast = 1'b0;     // last_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;            // data_out [31:0]
  logic        m_tlast;            // last_out

  // generator shadow state
  logic [31:0] twister_copy [0:STATE_WORDS-1];
  int unsigned next_word;
  logic        byte_mode_q = 1'b0;

  cipher_result_t pending_results[$];
  int unsigned    fail_count = 0;
  int unsigned    result_count = 0;
  int unsigned    cycle_count = 0;
  int unsigned    src_idle_pct = 0;
  int unsigned    sink_stall_pct = 0;

  // known values come from the standard default seed 5489
  directed_row_t directed_rows [0:DIR_ROWS-1] = '{
    '{1'b0, 32'h00000000, 1'b1, 32'd5489,     1'b0, 1'b1, 32'hd091bb5c},
    '{1'b0, 32'h00000000, 1'b0, 32'hffffffff, 1'b1, 1'b1, 32'h22ae9ef6},
    '{1'b0, 32'hffffffff, 1'b1, 32'd5489,     1'b0, 1'b1, 32'h2f6e44a3},
    '{1'b0, 32'hffffffff, 1'b0, 32'h00000000, 1'b1, 1'b1, 32'hdd516109},
    '{1'b0, 32'h00000000, 1'b1, 32'h00000000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'ha5a5a5a5, 1'b1, 32'hffffffff, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h00000000, 1'b1, 32'h80000000, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h12345678, 1'b0, 32'h00000000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h00000000, 1'b1, 32'h00000001, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'hffffffff, 1'b1, 32'h00000001, 1'b1, 1'b0, 32'h0},
    '{1'b1, 32'h00000000, 1'b1, 32'd5489,     1'b0, 1'b1, 32'h0000005c},
    '{1'b1, 32'hffffff00, 1'b0, 32'h00000000, 1'b0, 1'b1, 32'h000000f6},
    '{1'b1, 32'hffffffff, 1'b0, 32'h00000000, 1'b0, 1'b0, 32'h0},
    '{1'b1, 32'h000000ff, 1'b0, 32'hffffffff, 1'b1, 1'b0, 32'h0},
    '{1'b1, 32'h7fffff80, 1'b1, 32'hffffffff, 1'b1, 1'b0, 32'h0},
    '{1'b0, 32'h00000000, 1'b0, 32'h00000000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h80000001, 1'b1, 32'd5489,     1'b1, 1'b1, 32'h5091bb5d}
  };

  mt19937_keystream_xor uut (
    .clk             (clk),
    .rst             (rst),
    .byte_mode_we    (byte_mode_we),
    .byte_mode_wdata (byte_mode_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .s_tlast         (s_tlast),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tlast         (m_tlast)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // fill the shadow state from a seed
  function automatic void state_reseed(input logic [31:0] seed);
    twister_copy[0] = seed;
    for (int unsigned k = 1; k < STATE_WORDS; k++) begin
      twister_copy[k] = 32'(k) + INIT_MULT * (twister_copy[k-1] ^ (twister_copy[k-1] >> 30));
    end
    next_word = 0;
  endfunction

  // regenerate all words: top bit of the current word, middle bits of the next one
  function automatic void state_twist();
    logic [31:0] cur;
    logic [31:0] nxt;
    logic [31:0] far;
    for (int unsigned k = 0; k < STATE_WORDS; k++) begin
      cur = twister_copy[k];
      nxt = twister_copy[(k + 1) % STATE_WORDS];
      far = twister_copy[(k + SHIFT_M) % STATE_WORDS];
      twister_copy[k] = {1'b0, cur[31], nxt[30:1]} ^ (nxt[0] ? TWIST_XOR : 32'h0) ^ far;
    end
  endfunction

  // next tempered keystream word
  function automatic logic [31:0] keystream_next();
    logic [31:0] w;
    if (next_word == 0) state_twist();
    w = twister_copy[next_word];
    next_word = (next_word + 1) % STATE_WORDS;
    w = w ^ (w >> 11);
    w = w ^ ((w & TEMPER_B) << 7);
    w = w ^ ((w & TEMPER_C) << 15);
    w = w ^ (w >> 18);
    return w;
  endfunction

  // offer one request, predict its result once it is taken
  task automatic send_request(input logic [31:0] data, input logic first,
                              input logic [31:0] seed, input logic last,
                              input logic fixed, input logic [31:0] want);
    cipher_result_t exp;
    logic [31:0]    key;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {seed, data};
    s_tuser  <= first;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (first) state_reseed(seed);
    key = keystream_next();
    exp.data = data ^ key;
    if (byte_mode_q) exp.data = {24'h0, exp.data[7:0]};
    if (fixed) exp.data = want;
    exp.last = last;
    pending_results.push_back(exp);
    @(negedge clk);
  endtask

  // write the mode register once every result is out
  task automatic set_byte_mode(input logic mode);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    byte_mode_we    <= 1'b1;
    byte_mode_wdata <= mode;
    byte_mode_q = mode;
    @(negedge clk);
    byte_mode_we <= 1'b0;
  endtask

  // random buffers; an optional clean long buffer first crosses a twist boundary
  task automatic run_buffers(input int unsigned goal, input int unsigned long_len);
    int unsigned sent;
    int unsigned run_len;
    logic        fst;
    logic        lst;
    sent = 0;
    while (sent < goal) begin
      if (sent == 0 && long_len != 0) run_len = long_len;
      else if ($urandom_range(7) == 0) run_len = $urandom_range(80, 25);
      else run_len = $urandom_range(16, 1);
      for (int unsigned k = 0; k < run_len; k++) begin
        fst = (k == 0);
        lst = (k == run_len - 1);
        if (!(sent < long_len)) begin
          // broken buffers: dropped start, reseed mid-buffer, stray last flag
          if (k == 0 && $urandom_range(19) == 0) fst = 1'b0;
          if (k != 0 && $urandom_range(19) == 0) fst = 1'b1;
          if ($urandom_range(9) == 0) lst = $urandom_range(1);
        end
        send_request($urandom, fst, $urandom, lst, 1'b0, 32'h0);
        sent++;
      end
    end
  endtask

  // stimulus
  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    set_byte_mode(1'b0);

    // directed table
    for (int unsigned i = 0; i < DIR_ROWS; i++) begin
      if (directed_rows[i].mode != byte_mode_q) set_byte_mode(directed_rows[i].mode);
      send_request(directed_rows[i].data, directed_rows[i].first, directed_rows[i].seed,
                   directed_rows[i].last, directed_rows[i].fixed, directed_rows[i].want);
    end

    // random phases with different idle pressure
    set_byte_mode(1'b0);
    src_idle_pct = 0;
    sink_stall_pct = 0;
    run_buffers(650, $urandom_range(650, 625));

    set_byte_mode(1'b1);
    src_idle_pct = 80;
    sink_stall_pct = 0;
    run_buffers(60, 0);

    set_byte_mode(1'b0);
    src_idle_pct = 0;
    sink_stall_pct = 80;
    run_buffers(60, 0);

    set_byte_mode(1'b1);
    src_idle_pct = 28;
    sink_stall_pct = 28;
    run_buffers(60, 0);

    // drain
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("mt19937_keystream_xor regression: pass");
    end else begin
      $display("mt19937_keystream_xor regression: fail");
    end
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_FAILS)
          $display("unexpected result data %h last %b", m_tdata, m_tlast);
      end else begin
        if (m_tdata !== pending_results[0].data) begin
          fail_count++;
          if (fail_count <= SHOW_FAILS)
            $display("result %0d data_out: expected %h, got %h", result_count,
                     pending_results[0].data, m_tdata);
        end
        if (m_tlast !== pending_results[0].last) begin
          fail_count++;
          if (fail_count <= SHOW_FAILS)
            $display("result %0d last_out: expected %b, got %b", result_count,
                     pending_results[0].last, m_tlast);
        end
        void'(pending_results.pop_front());
      end
      result_count++;
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("mt19937_keystream_xor regression: fail");
      $finish;
    end
  end

endmodule
